>>> rtl/kli_pkg.sv
`default_nettype none

package kli_pkg;

   // default sizes
   localparam int NumChannelsDef = 6;
   localparam int MaxKeysDef     = 16;

   // fixed field widths
   localparam int TimeW   = 48;
   localparam int WordW   = 32;
   localparam int OutCh   = 6;
   localparam int DivSteps = 33;

   // request tdata layout
   localparam int NowLo    = 0;
   localparam int KidxLo   = 48;
   localparam int KoffLo   = 52;
   localparam int WidthLo  = 84;
   localparam int KcntLo   = 276;
   localparam int ReqDataW = 288;
   localparam int RspDataW = 192;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRKEY = 2'd1,
      OP_START = 2'd2,
      OP_OFF   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      OFF_IDX,
      OFF_IDX_M1,
      OFF_LAST,
      OFF_SEG
   } off_sel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_ST_RD0,
      S_ST_RD1,
      S_ST_DIVI,
      S_ST_DIV,
      S_ST_WR,
      S_TK_LOOP,
      S_TK_DIV,
      S_TK_FOLD,
      S_TK_SRCH0,
      S_TK_SRCH1,
      S_TK_RDA,
      S_TK_RDB,
      S_TK_WB,
      S_TK_MUL,
      S_TK_ADD,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic        take;
      logic        wr_key;
      logic        turn_off;
      logic        start;
      logic        tick_idle;
      logic        tick_go;
      off_sel_type off_sel;
      logic        ld_ra;
      logic        div_recip;
      logic        div_fold;
      logic        div_step;
      logic        wr_recip;
      logic        idx_one;
      logic        idx_inc;
      logic        fold_apply;
      logic        seg_set;
      logic        ld_alpha;
      logic        wrow_next;
      logic        ld_wb;
      logic        mul;
      logic        add_ch;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       n_ge2;
      logic       tick_ok;
      logic       fold_need;
      logic       div_done;
      logic       idx_last;
      logic       hit;
      logic       ch_last;
      logic       out_free;
   } sts_type;

endpackage

`default_nettype wire

>>> rtl/kli_ctrl.sv
`default_nettype none

module kli_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   input  kli_pkg::sts_type     sts,
   output kli_pkg::cmd_type     cmd
);

   kli_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kli_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kli_pkg::S_IDLE: begin
            if (req_tvalid) state_in = kli_pkg::S_DECODE;
         end
         kli_pkg::S_DECODE: begin
            case (sts.op)
               kli_pkg::OP_START: state_in = sts.n_ge2 ? kli_pkg::S_ST_RD0 : kli_pkg::S_IDLE;
               kli_pkg::OP_TICK:  state_in = sts.tick_ok ? kli_pkg::S_TK_LOOP : kli_pkg::S_EMIT;
               default:           state_in = kli_pkg::S_IDLE;
            endcase
         end
         kli_pkg::S_ST_RD0:  state_in = kli_pkg::S_ST_RD1;
         kli_pkg::S_ST_RD1:  state_in = kli_pkg::S_ST_DIVI;
         kli_pkg::S_ST_DIVI: state_in = kli_pkg::S_ST_DIV;
         kli_pkg::S_ST_DIV: begin
            if (sts.div_done) state_in = kli_pkg::S_ST_WR;
         end
         kli_pkg::S_ST_WR: begin
            state_in = sts.idx_last ? kli_pkg::S_IDLE : kli_pkg::S_ST_RD0;
         end
         kli_pkg::S_TK_LOOP: begin
            state_in = sts.fold_need ? kli_pkg::S_TK_DIV : kli_pkg::S_TK_SRCH0;
         end
         kli_pkg::S_TK_DIV: begin
            if (sts.div_done) state_in = kli_pkg::S_TK_FOLD;
         end
         kli_pkg::S_TK_FOLD:  state_in = kli_pkg::S_TK_SRCH0;
         kli_pkg::S_TK_SRCH0: state_in = kli_pkg::S_TK_SRCH1;
         kli_pkg::S_TK_SRCH1: begin
            if (sts.hit)           state_in = kli_pkg::S_TK_RDA;
            else if (sts.idx_last) state_in = kli_pkg::S_EMIT;
            else                   state_in = kli_pkg::S_TK_SRCH0;
         end
         kli_pkg::S_TK_RDA: state_in = kli_pkg::S_TK_RDB;
         kli_pkg::S_TK_RDB: state_in = kli_pkg::S_TK_WB;
         kli_pkg::S_TK_WB:  state_in = kli_pkg::S_TK_MUL;
         kli_pkg::S_TK_MUL: state_in = kli_pkg::S_TK_ADD;
         kli_pkg::S_TK_ADD: begin
            state_in = sts.ch_last ? kli_pkg::S_EMIT : kli_pkg::S_TK_MUL;
         end
         kli_pkg::S_EMIT: begin
            if (sts.out_free) state_in = kli_pkg::S_IDLE;
         end
         default: state_in = kli_pkg::S_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.off_sel = kli_pkg::OFF_IDX;
      req_tready = (state_ff == kli_pkg::S_IDLE);
      case (state_ff)
         kli_pkg::S_IDLE: begin
            cmd.take = req_tvalid;
         end
         kli_pkg::S_DECODE: begin
            case (sts.op)
               kli_pkg::OP_WRKEY: cmd.wr_key = 1'b1;
               kli_pkg::OP_OFF:   cmd.turn_off = 1'b1;
               kli_pkg::OP_START: begin
                  cmd.start   = 1'b1;
                  cmd.idx_one = 1'b1;
               end
               default: begin
                  cmd.off_sel   = kli_pkg::OFF_LAST;
                  cmd.tick_go   = sts.tick_ok;
                  cmd.tick_idle = !sts.tick_ok;
               end
            endcase
         end
         kli_pkg::S_ST_RD0: cmd.off_sel = kli_pkg::OFF_IDX_M1;
         kli_pkg::S_ST_RD1: cmd.ld_ra = 1'b1;
         kli_pkg::S_ST_DIVI: cmd.div_recip = 1'b1;
         kli_pkg::S_ST_DIV: cmd.div_step = !sts.div_done;
         kli_pkg::S_ST_WR: begin
            cmd.wr_recip = 1'b1;
            cmd.idx_inc  = !sts.idx_last;
         end
         kli_pkg::S_TK_LOOP: begin
            cmd.div_fold = sts.fold_need;
            cmd.idx_one  = !sts.fold_need;
         end
         kli_pkg::S_TK_DIV: cmd.div_step = !sts.div_done;
         kli_pkg::S_TK_FOLD: begin
            cmd.fold_apply = 1'b1;
            cmd.idx_one    = 1'b1;
         end
         kli_pkg::S_TK_SRCH1: begin
            cmd.seg_set   = sts.hit;
            cmd.tick_idle = !sts.hit && sts.idx_last;
            cmd.idx_inc   = !sts.hit && !sts.idx_last;
         end
         kli_pkg::S_TK_RDA: cmd.off_sel = kli_pkg::OFF_SEG;
         kli_pkg::S_TK_RDB: begin
            cmd.off_sel   = kli_pkg::OFF_SEG;
            cmd.ld_alpha  = 1'b1;
            cmd.wrow_next = 1'b1;
         end
         kli_pkg::S_TK_WB:  cmd.ld_wb = 1'b1;
         kli_pkg::S_TK_MUL: cmd.mul = 1'b1;
         kli_pkg::S_TK_ADD: cmd.add_ch = 1'b1;
         kli_pkg::S_EMIT:   cmd.emit = sts.out_free;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/kli_dp.sv
`default_nettype none

module kli_dp #(
   parameter int NUM_CHANNELS = kli_pkg::NumChannelsDef,
   parameter int MAX_KEYS     = kli_pkg::MaxKeysDef
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire [kli_pkg::ReqDataW-1:0]         req_tdata,
   input  wire [1:0]                           req_tuser,
   output logic [kli_pkg::RspDataW-1:0]        rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   input  kli_pkg::cmd_type                    cmd,
   output kli_pkg::sts_type                    sts
);

   localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int AW  = $clog2(MAX_KEYS + 1);
   localparam int CW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int RW  = NUM_CHANNELS * kli_pkg::WordW;
   localparam int TW  = kli_pkg::TimeW;
   localparam int WW  = kli_pkg::WordW;
   localparam int RspDataW_LOCAL = kli_pkg::RspDataW;

   // latched request
   logic [1:0]   op_ff;
   logic [TW-1:0] now_ff;
   logic [3:0]   kidx_ff;
   logic [WW-1:0] koff_ff;
   logic [RW-1:0] kwid_ff;
   logic [4:0]   kcnt_ff;

   // sequence state
   logic [AW-1:0] active_ff;
   logic [TW-1:0] start_ff;
   logic          running_ff;

   // work registers
   logic [KW-1:0] idx_ff;
   logic [KW-1:0] seg_ff;
   logic [WW-1:0] ra_ff;
   logic [WW-1:0] delta_ff;
   logic [WW:0]   quo_ff;
   logic [WW-1:0] rem_ff;
   logic [WW-1:0] dsr_ff;
   logic [5:0]    cnt_ff;
   logic          pzero_ff;
   logic [WW-1:0] alpha_ff;
   logic [RW-1:0] wa_ff;
   logic [RW-1:0] wb_ff;
   logic [63:0]   prod_ff;
   logic [CW-1:0] ch_ff;
   logic [WW-1:0] pulse_ff [NUM_CHANNELS];
   logic          idle_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [kli_pkg::RspDataW-1:0] rsp_data_ff;
   logic                     rsp_idle_ff;

   // memories
   logic [WW-1:0] off_mem   [MAX_KEYS];
   logic [WW-1:0] recip_mem [MAX_KEYS];
   logic [RW-1:0] wrow_mem  [MAX_KEYS];
   logic [WW-1:0] off_q_ff;
   logic [WW-1:0] recip_q_ff;
   logic [RW-1:0] wrow_q_ff;

   logic [KW-1:0] off_addr;
   logic [KW-1:0] wrow_addr;
   logic [AW-1:0] n_sat;
   logic [AW-1:0] active_m1;
   logic [WW-1:0] period;
   logic [WW:0]   trial;
   logic          ge;
   logic signed [WW-1:0] diff;
   logic signed [WW:0]   alpha_s;
   logic signed [63:0]   prod_s;
   logic [RspDataW_LOCAL-1:0] pulses_all;

   assign active_m1 = active_ff - AW'(1);
   assign n_sat = (32'(kcnt_ff) > MAX_KEYS) ? AW'(MAX_KEYS) : AW'(kcnt_ff);

   // offset read address
   always_comb begin
      case (cmd.off_sel)
         kli_pkg::OFF_IDX_M1: off_addr = idx_ff - KW'(1);
         kli_pkg::OFF_LAST:   off_addr = active_m1[KW-1:0];
         kli_pkg::OFF_SEG:    off_addr = seg_ff;
         default:             off_addr = idx_ff;
      endcase
   end

   assign wrow_addr = cmd.wrow_next ? (seg_ff + KW'(1)) : seg_ff;

   // key table and reciprocal memories
   always_ff @(posedge clock) begin
      if (cmd.wr_key && (32'(kidx_ff) < MAX_KEYS)) begin
         off_mem[KW'(kidx_ff)]  <= koff_ff;
         wrow_mem[KW'(kidx_ff)] <= kwid_ff;
      end
      if (cmd.wr_recip) begin
         recip_mem[idx_ff - KW'(1)] <= pzero_ff ? '0 : quo_ff[WW-1:0];
      end
      off_q_ff   <= off_mem[off_addr];
      recip_q_ff <= recip_mem[seg_ff];
      wrow_q_ff  <= wrow_mem[wrow_addr];
   end

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= req_tuser;
         now_ff  <= req_tdata[kli_pkg::NowLo +: TW];
         kidx_ff <= req_tdata[kli_pkg::KidxLo +: 4];
         koff_ff <= req_tdata[kli_pkg::KoffLo +: WW];
         kwid_ff <= req_tdata[kli_pkg::WidthLo +: RW];
         kcnt_ff <= req_tdata[kli_pkg::KcntLo +: 5];
      end
   end

   // sequence control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         start_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         if (cmd.turn_off) begin
            active_ff  <= '0;
            start_ff   <= '0;
            running_ff <= 1'b0;
         end
         if (cmd.start) begin
            active_ff  <= n_sat;
            start_ff   <= now_ff;
            running_ff <= (n_sat >= AW'(2));
         end
         if (cmd.tick_idle) running_ff <= 1'b0;
         if (cmd.fold_apply) start_ff <= start_ff + TW'(delta_ff - rem_ff);
      end
   end

   // shared restoring divider, one quotient bit a cycle
   assign period = off_q_ff - ra_ff;
   assign trial  = {rem_ff, quo_ff[WW]};
   assign ge     = (trial >= {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_recip) begin
         dsr_ff   <= period;
         pzero_ff <= (period == '0);
         quo_ff   <= {1'b1, {WW{1'b0}}};
         rem_ff   <= '0;
         cnt_ff   <= 6'(kli_pkg::DivSteps);
      end else if (cmd.div_fold) begin
         dsr_ff   <= off_q_ff;
         quo_ff   <= {1'b0, delta_ff};
         rem_ff   <= '0;
         cnt_ff   <= 6'(kli_pkg::DivSteps);
      end else if (cmd.div_step) begin
         rem_ff   <= ge ? WW'(trial - {1'b0, dsr_ff}) : trial[WW-1:0];
         quo_ff   <= {quo_ff[WW-1:0], ge};
         cnt_ff   <= cnt_ff - 6'd1;
      end
   end

   // key counter, segment, elapsed time
   always_ff @(posedge clock) begin
      if (cmd.idx_one) idx_ff <= KW'(1);
      else if (cmd.idx_inc) idx_ff <= idx_ff + KW'(1);
      if (cmd.ld_ra) ra_ff <= off_q_ff;
      if (cmd.seg_set) seg_ff <= idx_ff - KW'(1);
      if (cmd.tick_go) delta_ff <= WW'(now_ff - start_ff);
      else if (cmd.fold_apply) delta_ff <= rem_ff;
   end

   // blend: one channel at a time through the shared multiplier
   assign diff    = signed'(wb_ff[WW*ch_ff +: WW] - wa_ff[WW*ch_ff +: WW]);
   assign alpha_s = signed'({1'b0, alpha_ff});
   assign prod_s  = 64'(diff) * 64'(alpha_s);

   always_ff @(posedge clock) begin
      if (cmd.ld_alpha) begin
         alpha_ff <= WW'((delta_ff - off_q_ff) * recip_q_ff);
         wa_ff    <= wrow_q_ff;
      end
      if (cmd.ld_wb) begin
         wb_ff <= wrow_q_ff;
      end
      if (cmd.mul) prod_ff <= prod_s;
      if (cmd.add_ch) pulse_ff[ch_ff] <= wa_ff[WW*ch_ff +: WW] + prod_ff[63:32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff   <= '0;
         idle_ff <= 1'b0;
      end else begin
         if (cmd.ld_wb) ch_ff <= '0;
         else if (cmd.add_ch) ch_ff <= ch_ff + CW'(1);
         if (cmd.tick_idle) idle_ff <= 1'b1;
         else if (cmd.tick_go) idle_ff <= 1'b0;
      end
   end

   // gather channel results, unused channels read zero
   always_comb begin
      pulses_all = '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         pulses_all[WW*k +: WW] = pulse_ff[k];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_data_ff <= idle_ff ? '0 : pulses_all;
         rsp_idle_ff <= idle_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_idle_ff;

   // status
   assign sts.op        = kli_pkg::opcode_type'(op_ff);
   assign sts.n_ge2     = (n_sat >= AW'(2));
   assign sts.tick_ok   = running_ff && (now_ff >= start_ff);
   assign sts.fold_need = (off_q_ff != '0) && (delta_ff >= off_q_ff);
   assign sts.div_done  = (cnt_ff == 6'd0);
   assign sts.idx_last  = (AW'(idx_ff) == active_m1);
   assign sts.hit       = (delta_ff < off_q_ff);
   assign sts.ch_last   = (32'(ch_ff) == NUM_CHANNELS - 1);
   assign sts.out_free  = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

>>> rtl/keyframe_led_interpolator.sv
// Keyframe interpolator for up to six pulse-width channels.
// Start computes the reciprocal of each segment period. A tick searches the
// keys in order, and runs the 33-step shared divider first when the elapsed
// time wraps the loop. One request at a time; a tick waits to emit while an
// earlier result has not been taken on rsp_tready.
// Synchronous active-high reset: idle, zero keys, start time 0; key table
// contents are undefined until written.
`default_nettype none

module keyframe_led_interpolator #(
   parameter int NUM_CHANNELS = kli_pkg::NumChannelsDef,
   parameter int MAX_KEYS     = kli_pkg::MaxKeysDef
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // now_ms[47:0], key_index[51:48], key_offset_ms[83:52],
   // width_0..width_5[275:84], key_count[280:276], zero pad
   input  wire [kli_pkg::ReqDataW-1:0]  req_tdata,
   // opcode[1:0]
   input  wire [1:0]                    req_tuser,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   // pulse_0..pulse_5, 32 bits each from bit 0
   output logic [kli_pkg::RspDataW-1:0] rsp_tdata,
   // status[0]
   output logic                         rsp_tuser
);

   kli_pkg::cmd_type cmd;
   kli_pkg::sts_type sts;

   kli_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   kli_dp #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .MAX_KEYS     (MAX_KEYS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

`default_nettype wire

>>> dv/keyframe_led_interpolator_tb.sv
`timescale 1ns / 100ps

module keyframe_led_interpolator_tb;

   localparam int NCH         = 6;
   localparam int NKEYS       = 16;
   localparam int RAND_ITEMS  = 1900;
   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int DRAIN       = 200;

   // one request as the sequencer sees it
   typedef struct {
      kli_pkg::opcode_type op;
      logic [47:0] now;
      logic [3:0]  kidx;
      logic [31:0] koff;
      logic [191:0] widths;
      logic [4:0]  kcnt;
      bit          typed_idle;
   } key_req_type;

   typedef struct packed {
      logic [191:0] pulses;
      logic         idle;
   } pwm_frame_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [kli_pkg::ReqDataW-1:0] req_tdata;
   logic [1:0]          req_tuser;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [kli_pkg::RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;

   // shadow of the sequencer state
   logic [31:0] key_off[NKEYS];
   logic [31:0] key_w[NKEYS][NCH];
   logic [31:0] seg_recip[NKEYS];
   int          live_keys;
   logic [47:0] seq_start;
   bit          seq_running;

   pwm_frame_type pending_frames[$];
   key_req_type   directed_rows[$];
   int          errors = 0;
   int          cycles;
   bit          tx_calm;
   bit          rx_calm;
   int          rx_stall;

   keyframe_led_interpolator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // a + floor(signed(b-a) * alpha / 2^32), wrapping
   function automatic logic [31:0] blend_width(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] alpha);
      logic [31:0] diff;
      longint      d;
      longint      p;
      diff = b - a;
      d = longint'($signed(diff));
      p = d * longint'({32'b0, alpha});
      return a + p[63:32];
   endfunction

   // advance the shadow state; push the frame a tick produces
   function automatic void track_request(key_req_type r);
      pwm_frame_type f;
      logic [31:0] period;
      logic [63:0] quot;
      logic [47:0] elapsed;
      logic [31:0] delta;
      logic [31:0] loop_len;
      logic [31:0] whole;
      logic [31:0] alpha;
      int          seg;
      int          n;
      case (r.op)
         kli_pkg::OP_WRKEY: begin
            key_off[r.kidx] = r.koff;
            for (int c = 0; c < NCH; c++) key_w[r.kidx][c] = r.widths[32*c +: 32];
         end
         kli_pkg::OP_START: begin
            n = (r.kcnt > NKEYS) ? NKEYS : r.kcnt;
            live_keys = n;
            for (int i = 1; i < n; i++) begin
               period = key_off[i] - key_off[i-1];
               quot = (period == 0) ? 64'd0 : 64'h1_0000_0000 / {32'b0, period};
               seg_recip[i-1] = quot[31:0];
            end
            seq_start = r.now;
            seq_running = (n >= 2);
         end
         kli_pkg::OP_OFF: begin
            seq_running = 1'b0;
            live_keys = 0;
            seq_start = '0;
         end
         default: begin
            f.pulses = '0;
            f.idle = 1'b1;
            if (seq_running && live_keys >= 2 && r.now >= seq_start) begin
               elapsed = r.now - seq_start;
               delta = elapsed[31:0];
               loop_len = key_off[live_keys-1];
               // fold whole loops into the start time
               if (loop_len != 0 && delta >= loop_len) begin
                  whole = (delta / loop_len) * loop_len;
                  seq_start = seq_start + {16'b0, whole};
                  delta = delta - whole;
               end
               seg = -1;
               for (int i = 1; i < live_keys; i++)
                  if (seg < 0 && delta < key_off[i]) seg = i - 1;
               if (seg >= 0) begin
                  alpha = (delta - key_off[seg]) * seg_recip[seg];
                  for (int c = 0; c < NCH; c++)
                     f.pulses[32*c +: 32] = blend_width(key_w[seg][c], key_w[seg+1][c],
                                                        alpha);
                  f.idle = 1'b0;
               end
            end
            if (f.idle) seq_running = 1'b0;
            if (r.typed_idle) begin
               f.pulses = '0;
               f.idle = 1'b1;
            end
            pending_frames.push_back(f);
         end
      endcase
   endfunction

   function automatic key_req_type mk_req(kli_pkg::opcode_type op, logic [47:0] now,
                                          logic [3:0] kidx, logic [31:0] koff,
                                          logic [191:0] widths, logic [4:0] kcnt,
                                          bit typed_idle);
      key_req_type r;
      r.op = op;
      r.now = now;
      r.kidx = kidx;
      r.koff = koff;
      r.widths = widths;
      r.kcnt = kcnt;
      r.typed_idle = typed_idle;
      return r;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [191:0] rand_widths();
      logic [191:0] w;
      for (int c = 0; c < NCH; c++) w[32*c +: 32] = rand_word();
      return w;
   endfunction

   // present one request and hold it until taken
   task automatic send_request(key_req_type r);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.op;
      req_tdata  <= {7'b0, r.kcnt, r.widths, r.koff, r.kidx, r.now};
      do @(posedge clock); while (!req_tready);
      track_request(r);
   endtask

   // result side: random stalls, compare against the oldest pending frame
   initial begin
      pwm_frame_type exp_f;
      rx_stall = 0;
      rx_calm = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_frames.size() == 0) begin
               $error("unexpected result pulses=%h status=%b", rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               exp_f = pending_frames.pop_front();
               for (int c = 0; c < NCH; c++)
                  if (rsp_tdata[32*c +: 32] !== exp_f.pulses[32*c +: 32]) begin
                     $error("pulse_%0d expected %h actual %h", c,
                            exp_f.pulses[32*c +: 32], rsp_tdata[32*c +: 32]);
                     errors++;
                  end
               if (rsp_tuser !== exp_f.idle) begin
                  $error("status expected %b actual %b", exp_f.idle, rsp_tuser);
                  errors++;
               end
            end
            if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
            rx_stall = rx_calm ? 0 : $urandom_range(0, 11);
         end
         if (rx_stall > 0) begin
            rsp_tready <= 1'b0;
            rx_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("[keyframe_led_interpolator] ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [191:0] w_lo;
      logic [191:0] w_hi;
      logic [47:0]  base;
      logic [47:0]  t;
      logic [31:0]  o;
      logic [4:0]   kc;
      int           sent;
      int           nticks;
      bit           first;

      tx_calm = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = kli_pkg::OP_TICK;
      seq_running = 1'b0;
      live_keys = 0;
      seq_start = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      w_lo = {32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0};
      w_hi = {32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678, 32'h0,
              32'hFFFF_FFFF};

      // directed rows; idle results are typed in, the rest come from the shadow
      directed_rows = '{
         mk_req(kli_pkg::OP_TICK,  48'd0,    0, 0, '0, 0, 1),  // tick right after reset
         mk_req(kli_pkg::OP_START, 48'd5,    0, 0, '0, 1, 0),  // one key: stays idle
         mk_req(kli_pkg::OP_TICK,  48'd10,   0, 0, '0, 0, 1),
         mk_req(kli_pkg::OP_WRKEY, 48'd0,    0, 32'd0,   w_lo, 0, 0),
         mk_req(kli_pkg::OP_WRKEY, 48'd0,    1, 32'd100, w_hi, 0, 0),
         mk_req(kli_pkg::OP_WRKEY, 48'd0,    2, 32'd100, w_lo, 0, 0),  // zero period
         mk_req(kli_pkg::OP_WRKEY, 48'd0,    3, 32'd101, w_hi, 0, 0),  // period of one
         mk_req(kli_pkg::OP_START, 48'd1000, 0, 0, '0, 4, 0),
         mk_req(kli_pkg::OP_TICK,  48'd999,  0, 0, '0, 0, 1),  // before start time
         mk_req(kli_pkg::OP_START, 48'd1000, 0, 0, '0, 4, 0),
         mk_req(kli_pkg::OP_TICK,  48'd1000, 0, 0, '0, 0, 0),
         mk_req(kli_pkg::OP_TICK,  48'd1050, 0, 0, '0, 0, 0),
         mk_req(kli_pkg::OP_TICK,  48'd1100, 0, 0, '0, 0, 0),
         mk_req(kli_pkg::OP_TICK,  48'd1353, 0, 0, '0, 0, 0),  // wraps the loop
         mk_req(kli_pkg::OP_OFF,   48'd0,    0, 0, '0, 0, 0),
         mk_req(kli_pkg::OP_TICK,  48'd2000, 0, 0, '0, 0, 1),  // after turn off
         mk_req(kli_pkg::OP_START, 48'hFFFF_FFFF_FFF0, 0, 0, '0, 4, 0),
         mk_req(kli_pkg::OP_TICK,  48'hFFFF_FFFF_FFFF, 0, 0, '0, 0, 0),
         mk_req(kli_pkg::OP_WRKEY, 48'd0,    3, 32'd0, w_hi, 0, 0),    // zero loop length
         mk_req(kli_pkg::OP_START, 48'd0,    0, 0, '0, 4, 0),
         mk_req(kli_pkg::OP_TICK,  48'd50,   0, 0, '0, 0, 0),
         mk_req(kli_pkg::OP_TICK,  48'd5000, 0, 0, '0, 0, 1)   // no segment holds it
      };
      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // random episodes: load keys, start, then a run of ticks with some noise
      sent = 0;
      first = 1'b1;
      while (sent < RAND_ITEMS) begin
         tx_calm = ($urandom_range(0, 3) == 0);
         if (first || $urandom_range(0, 3) == 0) begin
            o = $urandom_range(0, 20);
            for (int k = 0; k < NKEYS; k++) begin
               send_request(mk_req(kli_pkg::OP_WRKEY, 48'({$urandom, $urandom}), k[3:0], o,
                                   rand_widths(), 5'($urandom), 0));
               sent++;
               case ($urandom_range(0, 15))
                  0, 1: o = o;
                  2: o = $urandom;
                  default: o = o + $urandom_range(1, 300);
               endcase
            end
            first = 1'b0;
         end else begin
            repeat ($urandom_range(1, 6)) begin
               t[3:0] = 4'($urandom_range(0, NKEYS - 1));
               send_request(mk_req(kli_pkg::OP_WRKEY, 48'({$urandom, $urandom}), t[3:0],
                                   key_off[t[3:0]] + $urandom_range(0, 50),
                                   rand_widths(), 5'($urandom), 0));
               sent++;
            end
         end
         case ($urandom_range(0, 9))
            0: kc = 5'($urandom_range(0, 1));
            1: kc = 5'($urandom_range(17, 31));
            default: kc = 5'($urandom_range(2, 16));
         endcase
         case ($urandom_range(0, 3))
            0: base = 48'({$urandom, $urandom});
            1: base = 48'hFFFF_FFFF_F000 + 48'($urandom_range(0, 4095));
            default: base = 48'($urandom_range(0, 1000000));
         endcase
         send_request(mk_req(kli_pkg::OP_START, base, 4'($urandom), $urandom,
                             rand_widths(), kc, 0));
         sent++;
         nticks = $urandom_range(4, 20);
         repeat (nticks) begin
            case ($urandom_range(0, 19))
               0: t = base - 48'($urandom_range(1, 100));
               1: t = 48'({$urandom, $urandom});
               2: t = base + 48'($urandom);
               default: t = base + 48'($urandom_range(0, 10000));
            endcase
            send_request(mk_req(kli_pkg::OP_TICK, t, 4'($urandom), $urandom, rand_widths(),
                                5'($urandom), 0));
            sent++;
            case ($urandom_range(0, 29))
               0: begin
                  send_request(mk_req(kli_pkg::OP_OFF, 48'({$urandom, $urandom}),
                                      4'($urandom), $urandom, rand_widths(),
                                      5'($urandom), 0));
                  sent++;
               end
               1: begin
                  t[3:0] = 4'($urandom_range(0, NKEYS - 1));
                  send_request(mk_req(kli_pkg::OP_WRKEY, base, t[3:0], key_off[t[3:0]],
                                      rand_widths(), 5'($urandom), 0));
                  sent++;
               end
               default: ;
            endcase
         end
      end
      req_tvalid <= 1'b0;

      while (pending_frames.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) begin
         $display("[keyframe_led_interpolator] OK");
      end else begin
         $display("[keyframe_led_interpolator] ERROR");
      end
      $finish;
   end

endmodule
